/* hdl/isort_pkg.sv */
package isort_pkg;

	localparam int VALUE_W   = 32;
	localparam int DEPTH_DEF = 64;

	typedef logic signed [VALUE_W-1:0] value_t;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_INS  = 4'b0010,
		ST_CMP  = 4'b0100,
		ST_EMIT = 4'b1000
	} state_t;

endpackage

/* hdl/isort_stream_if.sv */
interface isort_in_if;
	logic                  valid;
	logic                  ready;
	isort_pkg::value_t     value;
	logic                  last;

	modport source (output valid, output value, output last, input ready);
	modport sink   (input valid, input value, input last, output ready);
endinterface

interface isort_out_if;
	logic                  valid;
	logic                  ready;
	isort_pkg::value_t     sorted_value;
	logic                  end_of_run;
	logic                  overflow;

	modport source (output valid, output sorted_value, output end_of_run, output overflow,
		input ready);
	modport sink   (input valid, input sorted_value, input end_of_run, input overflow,
		output ready);
endinterface

/* hdl/insertion_sorter_unit.sv */
// Insertion: the s stored entries above the item are shifted up (0 to DEPTH-1), one per cycle,
// before it is written; no new item is taken until then, and a dropped item is not stored.
// Emission: once the last item is in, each entry is read from the store and then loaded into
// the output register; the next read waits until that result is loaded and the slot is free.
// Reset clears the count, the drop flag, the state and the output valid at once; the store
// itself is not cleared and needs no clearing pass.
module insertion_sorter_unit #(
	parameter int DEPTH = isort_pkg::DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	isort_in_if.sink           in_ch,
	isort_out_if.source        out_ch
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	// sorted store: one write and one registered read per cycle
	isort_pkg::value_t mem [DEPTH];
	isort_pkg::value_t rd_q;

	isort_pkg::state_t state_q;
	logic [CW-1:0]     count_q;      // valid entries in the store
	logic              dropped_q;    // some item of this set was dropped
	logic [AW-1:0]     pos_q;        // hole position during insertion
	logic              last_q;       // item under insertion closes the set
	isort_pkg::value_t v_q;          // item under insertion
	logic [AW-1:0]     emit_idx_q;   // next entry to read out

	// read issued last cycle, its data lands in the output register now
	logic              pend_s1;
	logic              pend_end_s1;
	logic              pend_ovf_s1;

	logic              out_valid_q;
	isort_pkg::value_t out_value_q;
	logic              out_end_q;
	logic              out_ovf_q;

	logic              mem_we;
	logic [AW-1:0]     mem_waddr;
	isort_pkg::value_t mem_wdata;
	logic              mem_re;
	logic [AW-1:0]     mem_raddr;
	logic              in_acc;
	logic              gt;
	logic              emit_issue;
	logic              emit_end;
	logic              full;

	assign in_acc   = in_ch.valid && in_ch.ready;
	assign gt       = rd_q > v_q;    // strictly greater: equal items keep arrival order
	assign full     = (count_q == CW'(DEPTH));
	assign emit_end = ({1'b0, emit_idx_q} + (AW+1)'(1)) == (AW+1)'(count_q);

	// one output slot, refilled only once the previous item has gone
	assign emit_issue = (state_q == isort_pkg::ST_EMIT) && !pend_s1
		&& (!out_valid_q || out_ch.ready);

	assign in_ch.ready         = (state_q == isort_pkg::ST_IDLE);
	assign out_ch.valid        = out_valid_q;
	assign out_ch.sorted_value = out_value_q;
	assign out_ch.end_of_run   = out_end_q;
	assign out_ch.overflow     = out_ovf_q;

	// store access per state
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = pos_q;
		mem_wdata = v_q;
		mem_re    = 1'b0;
		mem_raddr = pos_q - AW'(1);
		unique case (state_q)
			isort_pkg::ST_IDLE: begin
			end
			isort_pkg::ST_INS: begin
				// empty hole at the bottom: place the item, else fetch the neighbour below
				if (pos_q == '0) begin
					mem_we = 1'b1;
				end else begin
					mem_re = 1'b1;
				end
			end
			isort_pkg::ST_CMP: begin
				mem_we = 1'b1;
				if (gt) begin
					// shift the larger entry up, fetch the next one down
					mem_wdata = rd_q;
					mem_re    = (pos_q != AW'(1));
					mem_raddr = pos_q - AW'(2);
				end
			end
			isort_pkg::ST_EMIT: begin
				mem_re    = emit_issue;
				mem_raddr = emit_idx_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rd_q <= mem[mem_raddr];
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			v_q <= in_ch.value;
		end
		if (emit_issue) begin
			pend_end_s1 <= emit_end;
			pend_ovf_s1 <= dropped_q;
		end
		if (pend_s1) begin
			out_value_q <= rd_q;
			out_end_q   <= pend_end_s1;
			out_ovf_q   <= pend_ovf_s1;
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= isort_pkg::ST_IDLE;
			count_q     <= '0;
			dropped_q   <= 1'b0;
			pos_q       <= '0;
			last_q      <= 1'b0;
			emit_idx_q  <= '0;
			pend_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			pend_s1 <= emit_issue;
			if (pend_s1) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				isort_pkg::ST_IDLE: begin
					if (in_acc) begin
						emit_idx_q <= '0;
						if (full) begin
							// store full: drop the item, still close the set on last
							dropped_q <= 1'b1;
							if (in_ch.last) begin
								state_q <= isort_pkg::ST_EMIT;
							end
						end else begin
							last_q  <= in_ch.last;
							pos_q   <= count_q[AW-1:0];
							state_q <= isort_pkg::ST_INS;
						end
					end
				end
				isort_pkg::ST_INS: begin
					if (pos_q == '0) begin
						count_q <= count_q + CW'(1);
						state_q <= last_q ? isort_pkg::ST_EMIT : isort_pkg::ST_IDLE;
					end else begin
						state_q <= isort_pkg::ST_CMP;
					end
				end
				isort_pkg::ST_CMP: begin
					if (gt) begin
						pos_q <= pos_q - AW'(1);
						if (pos_q == AW'(1)) begin
							state_q <= isort_pkg::ST_INS;
						end
					end else begin
						count_q <= count_q + CW'(1);
						state_q <= last_q ? isort_pkg::ST_EMIT : isort_pkg::ST_IDLE;
					end
				end
				isort_pkg::ST_EMIT: begin
					if (emit_issue) begin
						emit_idx_q <= emit_idx_q + AW'(1);
						// final read issued: clear the set, result still in flight
						if (emit_end) begin
							count_q   <= '0;
							dropped_q <= 1'b0;
							state_q   <= isort_pkg::ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= isort_pkg::ST_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("element count beyond capacity");

	a_emit_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == isort_pkg::ST_EMIT |-> count_q != '0)
		else $error("read-out of an empty set");

	a_cmp_pos: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == isort_pkg::ST_CMP |-> pos_q != '0)
		else $error("compare with no entry below the hole");

	a_pend_load: assert property (@(posedge clk) disable iff (!arst_n)
		pend_s1 |=> out_valid_q)
		else $error("fetched item not presented");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		pend_s1 |-> !out_valid_q || $past(out_ch.ready))
		else $error("output register overwritten while held");
`endif

endmodule
